// ----- design/stun_binding_response_parser_core_defines.svh -----
// assertion macros shared by the parser rtl
`ifndef STUN_BINDING_RESPONSE_PARSER_CORE_DEFINES_SVH
`define STUN_BINDING_RESPONSE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/stun_bin_pkg.sv -----
// types and constants of the stun binding response parser
package stun_bin_pkg;

    localparam logic [31:0] STUN_COOKIE      = 32'h2112_A442;
    localparam logic [15:0] BINDING_RESPONSE = 16'h0101;
    localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
    localparam logic [15:0] ATTR_MAPPED      = 16'h0001;
    localparam logic [15:0] POS_MAX          = 16'hFFFF;
    localparam logic [15:0] HEADER_BYTES     = 16'd20;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TID_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TID_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TID_LOW  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_TYPE     = 3'd2,
        ST_BAD_COOKIE   = 3'd3,
        ST_TID_MISMATCH = 3'd4,
        ST_NO_ADDR      = 3'd5
    } t_status;

    // one datagram byte moving through the processing stage
    typedef struct packed {
        logic        fire;
        logic        last;
        logic [15:0] pos;
        logic [7:0]  data;
    } t_step;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
    } t_cfg_wr;

    // header results as held between bytes
    typedef struct packed {
        t_status     err;
        logic [15:0] msg_len;
    } t_hdr_info;

    // capture state after the current byte
    typedef struct packed {
        logic        found;
        logic        xored;
        logic [15:0] port;
        logic [31:0] ip;
    } t_walk_res;

endpackage

// ----- design/stun_binding_response_parser_core.sv -----
// stun binding response parser: one datagram byte per cycle, one result per datagram
// result: loaded into the output register when the final byte advances out of the input register
// throughput: one byte per cycle; the input register frees while a result waits
// only a final byte stalls, when the output register is still full
// reset: synchronous active-low, clears the parser, id registers and both handshakes
`include "stun_binding_response_parser_core_defines.svh"

module stun_binding_response_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_mapped_ip,
    output logic [15:0] o_mapped_port,
    output logic        o_was_xored
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_pos, n_pos;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [31:0] r_out_ip;
    logic [15:0] r_out_port;
    logic        r_out_xor;

    logic                    advance;
    stun_bin_pkg::t_step     step;
    stun_bin_pkg::t_cfg_wr   cfg;
    stun_bin_pkg::t_hdr_info hdr_info;
    stun_bin_pkg::t_status   err_upd, status;
    stun_bin_pkg::t_walk_res walk_res;

    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign step.fire = advance;
    assign step.last = r_in_last;
    assign step.pos  = r_pos;
    assign step.data = r_in_byte;

    assign cfg.en   = i_cfg_wr_en;
    assign cfg.idx  = i_cfg_index;
    assign cfg.data = i_cfg_wr_data;

    stun_bin_hdr_check u_hdr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (step),
        .o_info    (hdr_info),
        .o_err_upd (err_upd)
    );

    stun_bin_attr_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_hdr   (hdr_info),
        .o_res   (walk_res)
    );

    always_comb begin
        // position after this byte is below the header size
        if (r_pos < stun_bin_pkg::HEADER_BYTES - 16'd1)
            status = stun_bin_pkg::ST_SHORT;
        else if (err_upd != stun_bin_pkg::ST_OK)
            status = err_upd;
        else if (walk_res.found)
            status = stun_bin_pkg::ST_OK;
        else
            status = stun_bin_pkg::ST_NO_ADDR;

        n_pos = r_pos;
        if (advance) begin
            if (r_in_last)
                n_pos = '0;
            else if (r_pos != stun_bin_pkg::POS_MAX)
                n_pos = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
        end else begin
            r_pos <= n_pos;
            if (o_ready)
                r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_status <= status;
            if (status == stun_bin_pkg::ST_OK) begin
                r_out_ip   <= walk_res.ip;
                r_out_port <= walk_res.port;
                r_out_xor  <= walk_res.xored;
            end else begin
                r_out_ip   <= '0;
                r_out_port <= '0;
                r_out_xor  <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_mapped_ip   = r_out_ip;
    assign o_mapped_port = r_out_port;
    assign o_was_xored   = r_out_xor;

    `SBP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, advance && r_in_last,
                     r_out_valid, "final byte did not load a result")
    `SBP_ASSERT_NEXT(a_last_clears_pos, i_clk, i_rst_n, advance && r_in_last,
                     r_pos == 16'd0, "byte position not cleared after final byte")
    `SBP_ASSERT_NOW(a_fail_fields_zero, i_clk, i_rst_n,
                    r_out_valid && r_out_status != stun_bin_pkg::ST_OK,
                    r_out_ip == 32'd0 && r_out_port == 16'd0 && !r_out_xor,
                    "address fields set on a failed datagram")

endmodule

// ----- design/stun_bin_hdr_check.sv -----
// header checker: type, length, cookie and transaction id
module stun_bin_hdr_check (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stun_bin_pkg::t_cfg_wr  i_cfg,
    input  stun_bin_pkg::t_step    i_step,
    output stun_bin_pkg::t_hdr_info o_info,
    output stun_bin_pkg::t_status  o_err_upd
);

    logic [31:0]           r_tid_high, r_tid_mid, r_tid_low;
    logic [31:0]           r_shift, n_shift;
    logic [15:0]           r_len, n_len;
    stun_bin_pkg::t_status r_err, n_err, upd_err, code;
    logic [31:0]           sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tid_high <= '0;
            r_tid_mid  <= '0;
            r_tid_low  <= '0;
        end else if (i_cfg.en) begin
            unique case (i_cfg.idx)
                stun_bin_pkg::CFG_TID_HIGH: r_tid_high <= i_cfg.data;
                stun_bin_pkg::CFG_TID_MID:  r_tid_mid  <= i_cfg.data;
                stun_bin_pkg::CFG_TID_LOW:  r_tid_low  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sh      = {r_shift[23:0], i_step.data};
        code    = stun_bin_pkg::ST_OK;
        n_shift = r_shift;
        n_len   = r_len;
        if (i_step.fire && i_step.pos < stun_bin_pkg::HEADER_BYTES) begin
            n_shift = sh;
            unique case (i_step.pos)
                16'd1: begin
                    if (sh[15:0] != stun_bin_pkg::BINDING_RESPONSE)
                        code = stun_bin_pkg::ST_BAD_TYPE;
                end
                16'd3:  n_len = sh[15:0];
                16'd7: begin
                    if (sh != stun_bin_pkg::STUN_COOKIE)
                        code = stun_bin_pkg::ST_BAD_COOKIE;
                end
                16'd11: begin
                    if (sh != r_tid_high) code = stun_bin_pkg::ST_TID_MISMATCH;
                end
                16'd15: begin
                    if (sh != r_tid_mid) code = stun_bin_pkg::ST_TID_MISMATCH;
                end
                16'd19: begin
                    if (sh != r_tid_low) code = stun_bin_pkg::ST_TID_MISMATCH;
                end
                default: ;
            endcase
        end
        // first fault in byte order wins
        upd_err = (r_err == stun_bin_pkg::ST_OK) ? code : r_err;
        n_err   = upd_err;
        if (i_step.fire && i_step.last) begin
            n_shift = '0;
            n_len   = '0;
            n_err   = stun_bin_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_len   <= '0;
            r_err   <= stun_bin_pkg::ST_OK;
        end else begin
            r_shift <= n_shift;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

    assign o_info.err     = r_err;
    assign o_info.msg_len = r_len;
    assign o_err_upd      = upd_err;

endmodule

// ----- design/stun_bin_attr_walk.sv -----
// attribute walker: skips tlvs and captures the first mapped address
module stun_bin_attr_walk (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  stun_bin_pkg::t_step     i_step,
    input  stun_bin_pkg::t_hdr_info i_hdr,
    output stun_bin_pkg::t_walk_res o_res
);

    logic [15:0] r_start, n_start;
    logic [15:0] r_type, n_type;
    logic [15:0] r_vlen, n_vlen;
    logic        r_found, n_found;
    logic        r_stop, n_stop;
    logic        r_xor, n_xor;
    logic [15:0] r_port, n_port;
    logic [31:0] r_ip, n_ip;

    logic        active;
    logic [15:0] off;
    logic [17:0] hdr_end, skip_len, next_start, attr_end;
    logic        is_addr;
    stun_bin_pkg::t_walk_res upd;

    always_comb begin
        active = i_step.fire && i_step.pos >= stun_bin_pkg::HEADER_BYTES
                 && i_step.pos < stun_bin_pkg::POS_MAX && !r_stop && !r_found
                 && i_hdr.err == stun_bin_pkg::ST_OK && i_step.pos >= r_start;
        off      = i_step.pos - r_start;
        hdr_end  = {2'b0, stun_bin_pkg::HEADER_BYTES} + {2'b0, i_hdr.msg_len};
        attr_end = {2'b0, r_start} + 18'd4 + {2'b0, r_vlen};
        n_start = r_start;
        n_type  = r_type;
        n_vlen  = r_vlen;
        n_found = r_found;
        n_stop  = r_stop;
        n_xor   = r_xor;
        n_port  = r_port;
        n_ip    = r_ip;
        is_addr = 1'b0;
        skip_len   = '0;
        next_start = '0;
        if (active) begin
            unique case (off)
                16'd0: begin
                    if ({2'b0, r_start} >= hdr_end) n_stop = 1'b1;
                    else n_type = {8'h00, i_step.data};
                end
                16'd1: n_type = {r_type[7:0], i_step.data};
                16'd2: n_vlen = {8'h00, i_step.data};
                16'd3: begin
                    n_vlen  = {r_vlen[7:0], i_step.data};
                    is_addr = r_type == stun_bin_pkg::ATTR_XOR_MAPPED
                              || r_type == stun_bin_pkg::ATTR_MAPPED;
                    // value padded up to a four-byte boundary
                    skip_len   = ({2'b0, n_vlen} + 18'd3) & ~18'd3;
                    next_start = {2'b0, r_start} + 18'd4 + skip_len;
                    if (!is_addr || n_vlen < 16'd8)
                        n_start = (next_start > {2'b0, stun_bin_pkg::POS_MAX})
                                  ? stun_bin_pkg::POS_MAX : next_start[15:0];
                end
                default: begin
                    if (off == 16'd6 || off == 16'd7)
                        n_port = {r_port[7:0], i_step.data};
                    else if (off >= 16'd8 && off <= 16'd11)
                        n_ip = {r_ip[23:0], i_step.data};
                    if ({2'b0, i_step.pos} + 18'd1 == attr_end) begin
                        n_xor = r_type == stun_bin_pkg::ATTR_XOR_MAPPED;
                        if (n_xor) begin
                            n_port = n_port ^ stun_bin_pkg::STUN_COOKIE[31:16];
                            n_ip   = n_ip ^ stun_bin_pkg::STUN_COOKIE;
                        end
                        n_found = 1'b1;
                        n_stop  = 1'b1;
                    end
                end
            endcase
        end
        upd.found = n_found;
        upd.xored = n_xor;
        upd.port  = n_port;
        upd.ip    = n_ip;
        if (i_step.fire && i_step.last) begin
            n_start = stun_bin_pkg::HEADER_BYTES;
            n_type  = '0;
            n_vlen  = '0;
            n_found = 1'b0;
            n_stop  = 1'b0;
            n_xor   = 1'b0;
            n_port  = '0;
            n_ip    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= stun_bin_pkg::HEADER_BYTES;
            r_type  <= '0;
            r_vlen  <= '0;
            r_found <= 1'b0;
            r_stop  <= 1'b0;
            r_xor   <= 1'b0;
            r_port  <= '0;
            r_ip    <= '0;
        end else begin
            r_start <= n_start;
            r_type  <= n_type;
            r_vlen  <= n_vlen;
            r_found <= n_found;
            r_stop  <= n_stop;
            r_xor   <= n_xor;
            r_port  <= n_port;
            r_ip    <= n_ip;
        end
    end

    assign o_res = upd;

endmodule

// ----- tb/binding_reply_checker.sv -----
`timescale 1ns / 1ps
// checker for the stun parser: predicts each datagram result and compares it with the block
module binding_reply_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_mapped_ip,
    input  logic [15:0] i_mapped_port,
    input  logic        i_was_xored,
    output int          o_fail_count,
    output int          o_open_count
);

    typedef struct {
        stun_bin_pkg::t_status status;
        logic [31:0]           ip;
        logic [15:0]           port;
        logic                  xored;
    } t_binding_reply;

    t_binding_reply expected_replies[$];
    int             mismatches;

    logic [31:0] tid_high, tid_mid, tid_low;
    logic [15:0] byte_pos, hdr_type, msg_len;
    logic [15:0] tlv_kind, attr_len, attr_start, cap_port;
    logic [31:0] hdr_shift, cap_ip;
    stun_bin_pkg::t_status hdr_err;
    logic        found, stopped, cap_xor;

    function automatic void clear_datagram();
        byte_pos   = '0;
        hdr_type   = '0;
        msg_len    = '0;
        hdr_err    = stun_bin_pkg::ST_OK;
        hdr_shift  = '0;
        tlv_kind   = '0;
        attr_len   = '0;
        attr_start = stun_bin_pkg::HEADER_BYTES;
        found      = 1'b0;
        stopped    = 1'b0;
        cap_port   = '0;
        cap_ip     = '0;
        cap_xor    = 1'b0;
    endfunction

    // only the first header fault in byte order is kept
    function automatic void note_header_fault(input stun_bin_pkg::t_status code);
        if (hdr_err == stun_bin_pkg::ST_OK)
            hdr_err = code;
    endfunction

    function automatic void take_header_byte(input logic [15:0] p, input logic [7:0] b);
        hdr_shift = {hdr_shift[23:0], b};
        case (p)
            16'd1: begin
                hdr_type = hdr_shift[15:0];
                if (hdr_type != stun_bin_pkg::BINDING_RESPONSE)
                    note_header_fault(stun_bin_pkg::ST_BAD_TYPE);
            end
            16'd3:  msg_len = hdr_shift[15:0];
            16'd7:  if (hdr_shift != stun_bin_pkg::STUN_COOKIE)
                        note_header_fault(stun_bin_pkg::ST_BAD_COOKIE);
            16'd11: if (hdr_shift != tid_high)
                        note_header_fault(stun_bin_pkg::ST_TID_MISMATCH);
            16'd15: if (hdr_shift != tid_mid)
                        note_header_fault(stun_bin_pkg::ST_TID_MISMATCH);
            16'd19: if (hdr_shift != tid_low)
                        note_header_fault(stun_bin_pkg::ST_TID_MISMATCH);
            default: ;
        endcase
    endfunction

    function automatic void walk_attr_byte(input logic [31:0] p, input logic [7:0] b);
        logic [31:0] start, off, next;
        logic        is_addr;
        start = 32'(attr_start);
        if (stopped || found || hdr_err != stun_bin_pkg::ST_OK)
            return;
        if (p < start)
            return;
        off = p - start;
        if (off == 32'd0) begin
            // attributes must start inside the declared message length
            if (start >= 32'(stun_bin_pkg::HEADER_BYTES) + 32'(msg_len)) begin
                stopped = 1'b1;
                return;
            end
            tlv_kind = {8'd0, b};
        end else if (off == 32'd1) begin
            tlv_kind = {tlv_kind[7:0], b};
        end else if (off == 32'd2) begin
            attr_len = {8'd0, b};
        end else if (off == 32'd3) begin
            attr_len = {attr_len[7:0], b};
            is_addr  = (tlv_kind == stun_bin_pkg::ATTR_XOR_MAPPED ||
                        tlv_kind == stun_bin_pkg::ATTR_MAPPED);
            if (!is_addr || attr_len < 16'd8) begin
                next = start + 32'd4 + ((32'(attr_len) + 32'd3) & ~32'd3);
                attr_start = (next > 32'(stun_bin_pkg::POS_MAX)) ? stun_bin_pkg::POS_MAX
                                                                 : next[15:0];
            end
        end else begin
            if (off == 32'd6 || off == 32'd7)
                cap_port = {cap_port[7:0], b};
            else if (off >= 32'd8 && off <= 32'd11)
                cap_ip = {cap_ip[23:0], b};
            if (p + 32'd1 == start + 32'd4 + 32'(attr_len)) begin
                cap_xor = (tlv_kind == stun_bin_pkg::ATTR_XOR_MAPPED);
                if (cap_xor) begin
                    cap_port = cap_port ^ stun_bin_pkg::STUN_COOKIE[31:16];
                    cap_ip   = cap_ip ^ stun_bin_pkg::STUN_COOKIE;
                end
                found   = 1'b1;
                stopped = 1'b1;
            end
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        t_binding_reply r;
        if (byte_pos < stun_bin_pkg::HEADER_BYTES)
            take_header_byte(byte_pos, b);
        else if (byte_pos < stun_bin_pkg::POS_MAX)
            walk_attr_byte(32'(byte_pos), b);
        if (byte_pos < stun_bin_pkg::POS_MAX)
            byte_pos = byte_pos + 16'd1;
        if (last) begin
            if (byte_pos < stun_bin_pkg::HEADER_BYTES)
                r.status = stun_bin_pkg::ST_SHORT;
            else if (hdr_err != stun_bin_pkg::ST_OK)
                r.status = hdr_err;
            else if (found)
                r.status = stun_bin_pkg::ST_OK;
            else
                r.status = stun_bin_pkg::ST_NO_ADDR;
            r.ip    = (r.status == stun_bin_pkg::ST_OK) ? cap_ip : '0;
            r.port  = (r.status == stun_bin_pkg::ST_OK) ? cap_port : '0;
            r.xored = (r.status == stun_bin_pkg::ST_OK) ? cap_xor : 1'b0;
            expected_replies.push_back(r);
            clear_datagram();
        end
    endfunction

    function automatic void check_reply();
        t_binding_reply want;
        if (expected_replies.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: status %0d ip %h port %h xor %b",
                         i_status, i_mapped_ip, i_mapped_port, i_was_xored);
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        if (i_status != want.status || i_mapped_ip != want.ip ||
            i_mapped_port != want.port || i_was_xored != want.xored) begin
            if (mismatches < 10)
                $display("mismatch: exp st %0d ip %h port %h x %b, got st %0d ip %h port %h x %b",
                         want.status, want.ip, want.port, want.xored,
                         i_status, i_mapped_ip, i_mapped_port, i_was_xored);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tid_high = '0;
            tid_mid  = '0;
            tid_low  = '0;
            clear_datagram();
            expected_replies.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    stun_bin_pkg::CFG_TID_HIGH: tid_high = i_cfg_wr_data;
                    stun_bin_pkg::CFG_TID_MID:  tid_mid  = i_cfg_wr_data;
                    stun_bin_pkg::CFG_TID_LOW:  tid_low  = i_cfg_wr_data;
                    default: ;
                endcase
            end
            // a result leaving now always belongs to an older datagram
            if (i_rsp_valid && i_rsp_ready)
                check_reply();
            if (i_req_valid && i_req_ready)
                absorb_byte(i_byte_value, i_last_byte);
        end
        o_fail_count <= mismatches;
        o_open_count <= expected_replies.size();
    end

endmodule

// ----- tb/stun_binding_response_parser_core_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the stun parser: clock, reset, id setup, datagram stimulus and verdict
module stun_binding_response_parser_core_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_index   = stun_bin_pkg::CFG_TID_HIGH;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_byte_value  = '0;
    logic        i_last_byte   = 1'b0;
    logic        i_ready       = 1'b0;
    logic        o_ready, o_valid, o_was_xored;
    logic [2:0]  o_status;
    logic [31:0] o_mapped_ip;
    logic [15:0] o_mapped_port;

    int          fail_count, open_count, cycle_count;
    int          byte_count, frame_count;
    logic        calm = 1'b0;
    logic [31:0] tid_h = '0, tid_m = '0, tid_l = '0;
    logic [7:0]  frame[$];

    stun_binding_response_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_mapped_ip   (o_mapped_ip),
        .o_mapped_port (o_mapped_port),
        .o_was_xored   (o_was_xored)
    );

    binding_reply_checker reply_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_status      (o_status),
        .i_mapped_ip   (o_mapped_ip),
        .i_mapped_port (o_mapped_port),
        .i_was_xored   (o_was_xored),
        .o_fail_count  (fail_count),
        .o_open_count  (open_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // result side: random stall before taking each result
    initial begin : reply_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_ready = 1'b0;
                hold--;
            end else begin
                i_ready = 1'b1;
            end
            @(posedge i_clk);
            if (i_ready && o_valid)
                hold = pick_gap();
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_byte_value = b;
        i_last_byte  = last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame.size(); k++)
            push_byte(frame[k], k == frame.size() - 1);
        frame_count++;
        byte_count += frame.size();
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            frame.push_back(w[8*k +: 8]);
    endtask

    // header with a zero length, to be patched once the attributes are in
    task automatic put_header(input logic [15:0] mtype, input logic [31:0] cookie);
        frame.delete();
        frame.push_back(mtype[15:8]);
        frame.push_back(mtype[7:0]);
        frame.push_back(8'd0);
        frame.push_back(8'd0);
        put_word(cookie);
        put_word(tid_h);
        put_word(tid_m);
        put_word(tid_l);
    endtask

    task automatic put_attr(input logic [15:0] atype, input logic [15:0] alen);
        int pad;
        pad = (4 - int'(alen[1:0])) % 4;
        frame.push_back(atype[15:8]);
        frame.push_back(atype[7:0]);
        frame.push_back(alen[15:8]);
        frame.push_back(alen[7:0]);
        repeat (int'(alen) + pad) frame.push_back(8'($urandom));
    endtask

    task automatic set_length(input logic [15:0] len);
        frame[2] = len[15:8];
        frame[3] = len[7:0];
    endtask

    task automatic trim_frame(input int n);
        while (frame.size() > n) void'(frame.pop_back());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_index   = idx;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic write_tids(input logic [31:0] h, input logic [31:0] m, input logic [31:0] l);
        write_reg(stun_bin_pkg::CFG_TID_HIGH, h);
        write_reg(stun_bin_pkg::CFG_TID_MID, m);
        write_reg(stun_bin_pkg::CFG_TID_LOW, l);
        tid_h = h;
        tid_m = m;
        tid_l = l;
    endtask

    // stop sending and wait until every result is out
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (open_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic build_random_frame();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 4))
                    0: put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
                    1: put_attr(stun_bin_pkg::ATTR_MAPPED, 16'd8);
                    2: put_attr($urandom_range(0, 1) ? stun_bin_pkg::ATTR_XOR_MAPPED
                                                     : stun_bin_pkg::ATTR_MAPPED,
                                16'($urandom_range(0, 12)));
                    default: put_attr(16'($urandom), 16'($urandom_range(0, 12)));
                endcase
            end
            set_length(16'(frame.size() - 20));
            if ($urandom_range(0, 9) == 0)
                set_length(16'($urandom_range(0, frame.size() - 20)));
            // broken header: one byte damaged
            if (kind >= 70)
                frame[$urandom_range(0, 19)] ^= 8'($urandom_range(1, 255));
            if ($urandom_range(0, 9) == 0)
                trim_frame($urandom_range(1, frame.size()));
            else if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
        end else if (kind < 93) begin
            put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
            trim_frame($urandom_range(1, 19));
        end else begin
            frame.delete();
            repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ids still at their reset value of zero
        frame.delete();
        frame.push_back(8'hFF);
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        trim_frame(19);
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        send_frame();
        settle();

        write_tids($urandom, $urandom, $urandom);
        // wrong type and bad cookie: type wins
        put_header(16'h0111, stun_bin_pkg::STUN_COOKIE ^ 32'h0000_0100);
        send_frame();
        // bad cookie and bad id: cookie wins
        put_header(stun_bin_pkg::BINDING_RESPONSE, ~stun_bin_pkg::STUN_COOKIE);
        frame[19] ^= 8'h01;
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        frame[8] ^= 8'h80;
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        frame[13] ^= 8'h10;
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        frame[19] ^= 8'h01;
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
        set_length(16'd12);
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
        set_length(16'd12);
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_MAPPED, 16'd8);
        set_length(16'd12);
        send_frame();
        // odd-length unknown attribute needs padding before the address
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(16'h8022, 16'd5);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd12);
        set_length(16'(frame.size() - 20));
        send_frame();
        // address attribute too short for ipv4 is skipped
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd4);
        put_attr(stun_bin_pkg::ATTR_MAPPED, 16'd8);
        set_length(16'(frame.size() - 20));
        send_frame();
        // address value cut off by the final byte
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
        set_length(16'd12);
        trim_frame(30);
        send_frame();
        // attribute beyond the declared length
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
        send_frame();
        // attribute starts inside the declared length, value runs past it
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_MAPPED, 16'd8);
        set_length(16'd4);
        send_frame();
        // only the first address attribute counts
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
        put_attr(stun_bin_pkg::ATTR_MAPPED, 16'd8);
        set_length(16'(frame.size() - 20));
        send_frame();
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(stun_bin_pkg::ATTR_MAPPED, 16'd8);
        put_attr(stun_bin_pkg::ATTR_XOR_MAPPED, 16'd8);
        set_length(16'(frame.size() - 20));
        send_frame();
        // byte-swapped type is not an address attribute
        put_header(stun_bin_pkg::BINDING_RESPONSE, stun_bin_pkg::STUN_COOKIE);
        put_attr(16'h2000, 16'd8);
        set_length(16'(frame.size() - 20));
        send_frame();
        settle();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       write_tids('1, '1, '1);
                1:       write_tids('0, '0, '0);
                default: write_tids($urandom, $urandom, $urandom);
            endcase
            byte_count  = 0;
            frame_count = 0;
            while (byte_count < 160 || frame_count < 12) begin
                calm = ($urandom_range(0, 7) == 0);
                build_random_frame();
                send_frame();
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
